FILE: sv/glzw_pkg.sv
// Shared types and constants for the GIF LZW encoder.
package glzw_pkg;

  // Largest code width the design supports and the default table depth.
  localparam int MaxCodeBitsDef = 12;
  localparam int DictEntriesDef = 4096;

  // Bounds of the minimum code size register.
  localparam logic [3:0] MinCodeLo    = 4'd2;
  localparam logic [3:0] MinCodeHi    = 4'd8;
  localparam logic [3:0] MinCodeReset = 4'd8;

  // Code field width of a packer command, wide enough for any legal code.
  localparam int CodeW = 12;

  // One request to the bit packer.
  typedef struct packed {
    logic             emit;   // append a code to the bit stream
    logic             flush;  // pad to a byte after this code; last byte ends the frame
    logic [CodeW-1:0] code;
    logic [3:0]       width;
  } glzw_cmd_t;

endpackage

FILE: sv/glzw_dict.sv
// String table memory: one write port, one read port with registered data.
module glzw_dict
  import glzw_pkg::*;
#(
  parameter int AW = 12,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/glzw_packer.sv
// Bit packer: appends codes LSB first and drains whole bytes to the output register.
module glzw_packer
  import glzw_pkg::*;
#(
  parameter int MAX_CODE_BITS = MaxCodeBitsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  glzw_cmd_t  cmd,
  output logic       idle,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);

  localparam int PW = 8 * ((MAX_CODE_BITS + 14) / 8);
  localparam int CW = $clog2(PW + 1);

  logic [PW-1:0] acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          phase_r, phase_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          ol_r, ol_nxt;
  logic          load;
  logic [CodeW:0] mask;
  logic [CW-1:0] sum;

  assign load = (cnt_r >= CW'(8)) && (!ov_r || out_ready);
  assign idle = (cnt_r < CW'(8));

  // Append a code, or move one finished byte to the output register.
  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    ov_nxt    = ov_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    mask      = ((CodeW+1)'(1) << cmd.width) - (CodeW+1)'(1);
    sum       = cnt_r + CW'(cmd.width);
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (cmd.emit) begin
      acc_nxt = acc_r | (PW'(cmd.code & mask[CodeW-1:0]) << cnt_r);
      if (cmd.flush) begin
        cnt_nxt   = (sum + CW'(7)) & ~CW'(7);
        phase_nxt = 1'b1;
      end else begin
        cnt_nxt = sum;
      end
    end else if (load) begin
      ov_nxt  = 1'b1;
      ob_nxt  = acc_r[7:0];
      ol_nxt  = phase_r && (cnt_r == CW'(8));
      acc_nxt = acc_r >> 8;
      cnt_nxt = cnt_r - CW'(8);
      if (cnt_r == CW'(8)) begin
        phase_nxt = 1'b0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cnt_r   <= '0;
      phase_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid     = ov_r;
  assign out_byte      = ob_r;
  assign out_last_byte = ol_r;

endmodule

FILE: sv/gif_lzw_encoder_top.sv
// GIF LZW encoder top level: sequencer, string table search and packing.
// Each pixel is matched against the string table one entry at a time
// through a single read port, each entry passing through a read state and
// a compare state, from the first free code up to the current fill count.
// Appending a code waits while the packer drains bytes. No clearing pass
// is needed after reset; the fill count bounds the search.
module gif_lzw_encoder_top
  import glzw_pkg::*;
#(
  parameter int MAX_CODE_BITS = MaxCodeBitsDef,
  parameter int DICT_ENTRIES  = DictEntriesDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel_index,
  input  logic       in_last_pixel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_byte,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_min_code_size
);

  localparam int AW = $clog2(DICT_ENTRIES);
  localparam int NW = MAX_CODE_BITS + 1;
  localparam int DW = MAX_CODE_BITS + 8;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_CMP   = 4'd3;
  localparam logic [3:0] ST_MISS  = 4'd4;
  localparam logic [3:0] ST_UPD   = 4'd5;
  localparam logic [3:0] ST_CLR   = 4'd6;
  localparam logic [3:0] ST_LAST  = 4'd7;
  localparam logic [3:0] ST_FIN1  = 4'd8;
  localparam logic [3:0] ST_FIN2  = 4'd9;
  localparam logic [3:0] ST_WAIT  = 4'd10;

  localparam logic [3:0] MHi = (MAX_CODE_BITS - 2 < 8) ? 4'(MAX_CODE_BITS - 2) : MinCodeHi;

  logic [3:0]               state_r, state_nxt;
  logic [3:0]               mcs_r;
  logic [7:0]               k_r, k_nxt;
  logic                     last_r, last_nxt;
  logic [MAX_CODE_BITS-1:0] prefix_r, prefix_nxt;
  logic [NW-1:0]            nfc_r, nfc_nxt;
  logic [NW-1:0]            base_r, base_nxt;
  logic [NW-1:0]            ptr_r, ptr_nxt;
  logic [3:0]               width_r, width_nxt;
  logic                     started_r, started_nxt;

  logic [3:0]               m_eff;
  logic [NW-1:0]            clear_code;
  logic [NW-1:0]            first_free;
  logic [NW-1:0]            nfc_inc;
  logic [3:0]               width_inc;
  logic                     in_range;
  logic                     pk_idle;
  glzw_cmd_t                cmd;
  logic                     wr_en;
  logic [DW-1:0]            key;
  logic [DW-1:0]            rd_data;

  // Effective minimum code size and the codes derived from it.
  always_comb begin
    m_eff = mcs_r;
    if (m_eff > MHi) begin
      m_eff = MHi;
    end
    if (m_eff < MinCodeLo) begin
      m_eff = MinCodeLo;
    end
  end

  assign clear_code = NW'(1) << m_eff;
  assign first_free = clear_code + NW'(2);
  assign key        = {prefix_r, k_r};
  assign in_range   = (ptr_r < nfc_r) && (ptr_r < NW'(DICT_ENTRIES));
  assign nfc_inc    = (nfc_r != {NW{1'b1}}) ? nfc_r + NW'(1) : nfc_r;
  assign width_inc  = (nfc_inc > (NW'(1) << width_r)) ? width_r + 4'd1 : width_r;
  assign in_ready   = (state_r == ST_IDLE);
  assign wr_en      = (state_r == ST_UPD) && (nfc_r < NW'(DICT_ENTRIES));

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    last_nxt    = last_r;
    prefix_nxt  = prefix_r;
    nfc_nxt     = nfc_r;
    base_nxt    = base_r;
    ptr_nxt     = ptr_r;
    width_nxt   = width_r;
    started_nxt = started_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          k_nxt     = in_pixel_index & 8'(clear_code - NW'(1));
          last_nxt  = in_last_pixel;
          ptr_nxt   = base_r;
          state_nxt = started_r ? ST_RD : ST_START;
        end
      end
      ST_START: begin
        if (pk_idle) begin
          cmd.emit    = 1'b1;
          cmd.code    = CodeW'(clear_code);
          cmd.width   = m_eff + 4'd1;
          nfc_nxt     = first_free;
          base_nxt    = first_free;
          width_nxt   = m_eff + 4'd1;
          prefix_nxt  = MAX_CODE_BITS'(k_r);
          started_nxt = 1'b1;
          state_nxt   = ST_LAST;
        end
      end
      ST_RD: begin
        state_nxt = in_range ? ST_CMP : ST_MISS;
      end
      ST_CMP: begin
        if (rd_data == key) begin
          prefix_nxt = MAX_CODE_BITS'(ptr_r);
          state_nxt  = ST_LAST;
        end else begin
          ptr_nxt   = ptr_r + NW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_MISS: begin
        if (pk_idle) begin
          cmd.emit  = 1'b1;
          cmd.code  = CodeW'(prefix_r);
          cmd.width = width_r;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        nfc_nxt    = nfc_inc;
        width_nxt  = width_inc;
        prefix_nxt = MAX_CODE_BITS'(k_r);
        state_nxt  = (width_inc >= 4'(MAX_CODE_BITS)) ? ST_CLR : ST_LAST;
      end
      ST_CLR: begin
        if (pk_idle) begin
          cmd.emit  = 1'b1;
          cmd.code  = CodeW'(clear_code);
          cmd.width = width_r;
          nfc_nxt   = first_free;
          base_nxt  = first_free;
          width_nxt = m_eff + 4'd1;
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = last_r ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        if (pk_idle) begin
          cmd.emit  = 1'b1;
          cmd.code  = CodeW'(prefix_r);
          cmd.width = width_r;
          state_nxt = ST_FIN2;
        end
      end
      ST_FIN2: begin
        if (pk_idle) begin
          cmd.emit  = 1'b1;
          cmd.flush = 1'b1;
          cmd.code  = CodeW'(clear_code + NW'(1));
          cmd.width = width_r;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (pk_idle) begin
          started_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mcs_r     <= MinCodeReset;
      prefix_r  <= '0;
      nfc_r     <= '0;
      base_r    <= '0;
      width_r   <= MinCodeReset + 4'd1;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      prefix_r  <= prefix_nxt;
      nfc_r     <= nfc_nxt;
      base_r    <= base_nxt;
      width_r   <= width_nxt;
      started_r <= started_nxt;
      if (cfg_wr_en) begin
        mcs_r <= cfg_min_code_size;
      end
    end
  end

  // Item payload and search pointer.
  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    last_r <= last_nxt;
    ptr_r  <= ptr_nxt;
  end

  glzw_dict #(
    .AW (AW),
    .DW (DW)
  ) u_dict (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (nfc_r[AW-1:0]),
    .wr_data (key),
    .rd_addr (ptr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  glzw_packer #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_packer (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .idle          (pk_idle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

  // The table never waits at full width between items.
  a_width_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && started_r) |-> (width_r < 4'(MAX_CODE_BITS)))
    else $error("code width reached maximum without a clear");

  // A compare only follows a read of an entry inside the table.
  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> $past(in_range))
    else $error("compared an entry outside the table");

  // The fill count never falls below the table base during a frame.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (nfc_r >= base_r))
    else $error("fill count below table base");

  // Commands go to the packer only when it has room.
  a_cmd_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> pk_idle)
    else $error("code appended while packer was draining");

endmodule

FILE: tb/sv/tb_gif_lzw_encoder_top.sv
// Self-checking testbench for the GIF LZW encoder top level.
`timescale 1ns / 1ps

module tb_gif_lzw_encoder_top
  import glzw_pkg::*;
();

  localparam int ClkHalf    = 6;
  localparam int IdleLimit  = 40000;
  localparam int SettleCyc  = 80;
  localparam int LongHold   = 400;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } lzw_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_pixel_index;
  logic       in_last_pixel;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last_byte;
  logic       cfg_wr_en;
  logic [3:0] cfg_min_code_size;

  gif_lzw_encoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_index   (in_pixel_index),
    .in_last_pixel    (in_last_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_min_code_size(cfg_min_code_size)
  );

  // Encoder state mirrored by the testbench.
  int         string_table [int];
  logic [3:0] min_size_reg;
  int         cur_prefix;
  int         free_code;
  int         code_bits;
  logic [31:0] bit_buf;
  int         bit_fill;
  bit         in_frame;

  lzw_byte_t  pending_bytes [$];
  int         n_errors;
  int         n_pixels;
  int         n_bytes;
  int         n_frames;
  bit         hold_req;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  // Effective code size after clamping the register.
  function automatic int clamped_size();
    int m;
    m = int'(min_size_reg);
    if (m > 8) m = 8;
    if (m > MaxCodeBitsDef - 2) m = MaxCodeBitsDef - 2;
    if (m < 2) m = 2;
    return m;
  endfunction

  // Append a code to the bit buffer and queue every completed byte.
  function automatic void pack_code(input int code, input int bits);
    lzw_byte_t nb;
    bit_buf  = bit_buf | ((32'(code) & ((32'd1 << bits) - 1)) << bit_fill);
    bit_fill = bit_fill + bits;
    while (bit_fill >= 8) begin
      nb.data = bit_buf[7:0];
      nb.last = 1'b0;
      pending_bytes = {pending_bytes, nb};
      bit_buf  = bit_buf >> 8;
      bit_fill = bit_fill - 8;
    end
  endfunction

  function automatic void restart_table(input int m);
    string_table.delete();
    free_code = (1 << m) + 2;
    code_bits = m + 1;
  endfunction

  // Work out the bytes that one accepted pixel produces.
  function automatic void encode_pixel(input logic [7:0] pix, input logic last);
    int m;
    int clr;
    int sym;
    int key;
    int queued_before;
    m   = clamped_size();
    clr = 1 << m;
    sym = int'(pix) & (clr - 1);
    queued_before = pending_bytes.size();
    if (!in_frame) begin
      bit_buf  = '0;
      bit_fill = 0;
      restart_table(m);
      pack_code(clr, code_bits);
      cur_prefix = sym;
      in_frame   = 1'b1;
    end else begin
      key = (cur_prefix << 8) | sym;
      if (string_table.exists(key)) begin
        cur_prefix = string_table[key];
      end else begin
        pack_code(cur_prefix, code_bits);
        if (free_code < DictEntriesDef) string_table[key] = free_code;
        if (free_code < 'h1FFF) free_code++;
        if (free_code > (1 << code_bits)) code_bits++;
        cur_prefix = sym;
        if (code_bits >= MaxCodeBitsDef) begin
          pack_code(clr, code_bits);
          restart_table(m);
        end
      end
    end
    if (last) begin
      pack_code(cur_prefix, code_bits);
      pack_code(clr + 1, code_bits);
      if (bit_fill % 8 != 0) pack_code(0, 8 - bit_fill % 8);
      if (pending_bytes.size() > queued_before)
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
      bit_buf  = '0;
      bit_fill = 0;
      in_frame = 1'b0;
      n_frames++;
    end
  endfunction

  // Send one pixel after a random gap; valid stays high after the transfer.
  task automatic send_pixel(input logic [7:0] pix, input logic last);
    int   gap;
    logic rdy;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_index <= pix;
    in_last_pixel  <= last;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    encode_pixel(pix, last);
    n_pixels++;
  endtask

  // Wait until every expected byte has arrived and the block has settled.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  // Register write; only issued while the block is idle.
  task automatic write_min_size(input logic [3:0] val);
    cfg_wr_en         <= 1'b1;
    cfg_min_code_size <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_size_reg = val;
  endtask

  task automatic send_frame(input int len, input int alphabet, input bit wide);
    logic [7:0] pix;
    for (int i = 0; i < len; i++) begin
      pix = wide ? 8'($urandom) : 8'($urandom_range(0, alphabet - 1));
      send_pixel(pix, i == len - 1);
    end
  endtask

  // Single-pixel frames at the extremes of the pixel field.
  task automatic test_single_pixel();
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b1);
    wait_drain();
  endtask

  // Long runs of one value build hits on longer and longer strings.
  task automatic test_runs();
    write_min_size(4'd2);
    for (int i = 0; i < 12; i++) send_pixel(8'h03, i == 11);
    wait_drain();
  endtask

  // Out-of-range register values and pixels with bits above the code size.
  task automatic test_clamp();
    write_min_size(4'd0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b1);
    wait_drain();
    write_min_size(4'd15);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h7F, 1'b1);
    wait_drain();
    write_min_size(4'd1);
    send_pixel(8'hFE, 1'b1);
    wait_drain();
  endtask

  // The receiver stalls for a long stretch while pixels keep coming.
  task automatic test_backpressure();
    write_min_size(4'd3);
    hold_req = 1'b1;
    send_frame(30, 8, 1'b0);
    wait_drain();
  endtask

  // Random frames with random register settings between them.
  task automatic test_random_frames(input int target);
    int len;
    int m;
    while (n_pixels < target) begin
      write_min_size(4'($urandom_range(0, 15)));
      m   = clamped_size();
      len = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0: send_frame(len, 1 << m, 1'b1);
        1: send_frame(len, 2, 1'b0);
        default: send_frame(len, 1 << m, 1'b0);
      endcase
      wait_drain();
    end
    write_min_size(4'd8);
    send_frame(20, 256, 1'b0);
    wait_drain();
  endtask

  // Result side: random stalls, and a long hold when asked for.
  initial begin : result_side
    int        stall;
    logic      vld;
    lzw_byte_t got;
    lzw_byte_t want;
    out_ready = 1'b0;
    forever begin
      stall = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (hold_req) begin
        stall    = LongHold;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        vld      = out_valid;
        got.data = out_byte;
        got.last = out_last_byte;
        @(posedge clk);
      end while (!(vld && rst_n));
      n_bytes++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b", $time, got.data, got.last);
        n_errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (got.data !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, got.data);
          n_errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: out_last_byte expected %0b actual %0b",
                   $time, want.last, got.last);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("tb_gif_lzw_encoder_top: done, errors");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_pixel_index    = '0;
    in_last_pixel     = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_min_code_size = MinCodeReset;
    n_errors = 0;
    n_pixels = 0;
    n_bytes  = 0;
    n_frames = 0;
    hold_req = 1'b0;
    min_size_reg = MinCodeReset;
    cur_prefix = 0;
    free_code  = 0;
    code_bits  = clamped_size() + 1;
    bit_buf    = '0;
    bit_fill   = 0;
    in_frame   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_pixel();
    test_runs();
    test_clamp();
    test_backpressure();
    test_random_frames(130);

    if (pending_bytes.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, pending_bytes.size());
      n_errors++;
    end
    $display("Covered %0d pixels in %0d frames, %0d bytes checked, code sizes 2 to 8,",
             n_pixels, n_frames, n_bytes);
    $display("including clamped register values, single-pixel frames and a long stall.");
    if (n_errors == 0) begin
      $display("tb_gif_lzw_encoder_top: done, clean");
    end else begin
      $display("tb_gif_lzw_encoder_top: done, errors");
    end
    $finish;
  end

endmodule
